### sv/prim_mst_pkg.sv
package prim_mst_pkg;

   localparam int MAX_NODES   = 16;
   localparam int WEIGHT_BITS = 16;

   localparam int NODE_BITS = $clog2(MAX_NODES);
   localparam int CNT_BITS  = $clog2(MAX_NODES + 1);
   localparam int KEY_BITS  = WEIGHT_BITS + 1;
   localparam int ADDR_BITS = 2 * NODE_BITS;
   localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;

   localparam logic [CNT_BITS-1:0] NODE_COUNT_RESET = CNT_BITS'(MAX_NODES);
   localparam logic [KEY_BITS-1:0] KEY_INF          = {KEY_BITS{1'b1}};

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_RUN   = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INIT,
      ST_SCAN,
      ST_MARK,
      ST_RELAX,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic write_entry;
      logic init;
      logic scan_step;
      logic mark;
      logic relax_step;
      logic emit_step;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic idx_last;
      logic round_last;
      logic emit_last;
   } sts_type;

endpackage

### sv/prim_mst_ram.sv
module prim_mst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/prim_mst_ctrl.sv
module prim_mst_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_cmd,
   input  prim_mst_pkg::sts_type sts,
   output prim_mst_pkg::cmd_type cmd,
   output logic                 busy
);

   prim_mst_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prim_mst_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         prim_mst_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = prim_mst_pkg::ST_IDLE;
            end
         end
         prim_mst_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_cmd == prim_mst_pkg::CMD_RUN) begin
                  state_in = prim_mst_pkg::ST_INIT;
               end else begin
                  cmd.write_entry = 1'b1;
               end
            end
         end
         prim_mst_pkg::ST_INIT: begin
            cmd.init = 1'b1;
            state_in = prim_mst_pkg::ST_SCAN;
         end
         prim_mst_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.idx_last) begin
               state_in = prim_mst_pkg::ST_MARK;
            end
         end
         prim_mst_pkg::ST_MARK: begin
            cmd.mark = 1'b1;
            state_in = prim_mst_pkg::ST_RELAX;
         end
         prim_mst_pkg::ST_RELAX: begin
            cmd.relax_step = 1'b1;
            if (sts.idx_last) begin
               state_in = prim_mst_pkg::ST_DRAIN;
            end
         end
         prim_mst_pkg::ST_DRAIN: begin
            if (sts.round_last) begin
               state_in = prim_mst_pkg::ST_EMIT;
            end else begin
               state_in = prim_mst_pkg::ST_SCAN;
            end
         end
         prim_mst_pkg::ST_EMIT: begin
            cmd.emit_step = 1'b1;
            if (sts.emit_last) begin
               state_in = prim_mst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prim_mst_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### sv/prim_mst_dpath.sv
module prim_mst_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  prim_mst_pkg::cmd_type                 cmd,
   output prim_mst_pkg::sts_type                 sts,
   input  logic                                  csr_wr_en,
   input  logic [prim_mst_pkg::CNT_BITS-1:0]     csr_wr_data,
   input  logic [prim_mst_pkg::NODE_BITS-1:0]    req_row,
   input  logic [prim_mst_pkg::NODE_BITS-1:0]    req_col,
   input  logic [prim_mst_pkg::WEIGHT_BITS-1:0]  req_weight,
   output logic                                  rsp_valid,
   output logic [prim_mst_pkg::NODE_BITS-1:0]    rsp_parent,
   output logic [prim_mst_pkg::NODE_BITS-1:0]    rsp_child,
   output logic                                  rsp_has_parent,
   output logic                                  rsp_last
);

   localparam int NB = prim_mst_pkg::NODE_BITS;
   localparam int KB = prim_mst_pkg::KEY_BITS;
   localparam int WB = prim_mst_pkg::WEIGHT_BITS;
   localparam int CB = prim_mst_pkg::CNT_BITS;
   localparam int AB = prim_mst_pkg::ADDR_BITS;
   localparam int MN = prim_mst_pkg::MAX_NODES;

   // control registers
   logic [CB-1:0] node_count_ff, node_count_in;
   logic [AB-1:0] clr_addr_ff, clr_addr_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // run registers
   logic [NB-1:0] idx_ff, idx_in;
   logic [NB-1:0] round_ff, round_in;
   logic [NB-1:0] pick_ff, pick_in;
   logic [KB-1:0] bkey_ff, bkey_in;
   logic          found_ff, found_in;
   logic          rv_ff, rv_in;
   logic [NB-1:0] ridx_ff, ridx_in;

   logic [KB-1:0] key_ff [MN];
   logic [KB-1:0] key_in [MN];
   logic [NB-1:0] par_ff [MN];
   logic [NB-1:0] par_in [MN];
   logic          in_tree_ff [MN];
   logic          in_tree_in [MN];
   logic          known_ff [MN];
   logic          known_in [MN];

   // result registers
   logic [NB-1:0] rsp_parent_ff, rsp_parent_in;
   logic [NB-1:0] rsp_child_ff, rsp_child_in;
   logic          rsp_has_parent_ff, rsp_has_parent_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [NB-1:0] n_m1;
   logic [NB-1:0] child;
   logic [KB-1:0] scan_key;
   logic          scan_take;
   logic          rlx_take;

   logic          ram_wr_en;
   logic [AB-1:0] ram_wr_addr;
   logic [WB-1:0] ram_wr_data;
   logic [WB-1:0] ram_rd_data;

   prim_mst_ram #(
      .WIDTH(WB),
      .DEPTH(prim_mst_pkg::MAT_DEPTH)
   ) u_matrix (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (cmd.relax_step),
      .rd_addr({pick_ff, idx_ff}),
      .rd_data(ram_rd_data)
   );

   assign ram_wr_en   = cmd.clear_step | cmd.write_entry;
   assign ram_wr_addr = cmd.clear_step ? clr_addr_ff : {req_row, req_col};
   assign ram_wr_data = cmd.clear_step ? '0 : req_weight;

   always_comb begin
      if (node_count_ff < CB'(2)) begin
         n_m1 = NB'(1);
      end else if (node_count_ff > CB'(MN)) begin
         n_m1 = NB'(MN - 1);
      end else begin
         n_m1 = NB'(node_count_ff - CB'(1));
      end
   end

   assign child     = NB'(idx_ff + NB'(1));
   assign scan_key  = key_ff[idx_ff];
   assign scan_take = !in_tree_ff[idx_ff] && (!found_ff || (scan_key < bkey_ff));
   assign rlx_take  = rv_ff && (ram_rd_data != '0) && !in_tree_ff[ridx_ff]
                      && ({1'b0, ram_rd_data} < key_ff[ridx_ff]);

   assign sts.clear_last = &clr_addr_ff;
   assign sts.idx_last   = (idx_ff == n_m1);
   assign sts.round_last = (round_ff == n_m1);
   assign sts.emit_last  = (child == n_m1);

   always_comb begin
      node_count_in     = csr_wr_en ? csr_wr_data : node_count_ff;
      clr_addr_in       = cmd.clear_step ? AB'(clr_addr_ff + AB'(1)) : clr_addr_ff;
      rsp_valid_in      = cmd.emit_step;
      idx_in            = idx_ff;
      round_in          = round_ff;
      pick_in           = pick_ff;
      bkey_in           = bkey_ff;
      found_in          = found_ff;
      rv_in             = cmd.relax_step;
      ridx_in           = idx_ff;
      key_in            = key_ff;
      par_in            = par_ff;
      in_tree_in        = in_tree_ff;
      known_in          = known_ff;
      rsp_parent_in     = rsp_parent_ff;
      rsp_child_in      = rsp_child_ff;
      rsp_has_parent_in = rsp_has_parent_ff;
      rsp_last_in       = rsp_last_ff;

      if (cmd.init) begin
         idx_in   = '0;
         round_in = '0;
         found_in = 1'b0;
         for (int i = 0; i < MN; i++) begin
            key_in[i]     = prim_mst_pkg::KEY_INF;
            par_in[i]     = '0;
            in_tree_in[i] = 1'b0;
            known_in[i]   = 1'b0;
         end
         key_in[0] = '0;
      end

      if (cmd.scan_step) begin
         if (scan_take) begin
            pick_in  = idx_ff;
            bkey_in  = scan_key;
            found_in = 1'b1;
         end
         idx_in = sts.idx_last ? '0 : NB'(idx_ff + NB'(1));
      end

      if (cmd.mark) begin
         in_tree_in[pick_ff] = 1'b1;
         found_in            = 1'b0;
         round_in            = NB'(round_ff + NB'(1));
      end

      if (cmd.relax_step) begin
         idx_in = sts.idx_last ? '0 : NB'(idx_ff + NB'(1));
      end

      if (rlx_take) begin
         key_in[ridx_ff]   = {1'b0, ram_rd_data};
         par_in[ridx_ff]   = pick_ff;
         known_in[ridx_ff] = 1'b1;
      end

      if (cmd.emit_step) begin
         idx_in            = child;
         rsp_child_in      = child;
         rsp_has_parent_in = known_ff[child];
         rsp_parent_in     = known_ff[child] ? par_ff[child] : '0;
         rsp_last_in       = sts.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= prim_mst_pkg::NODE_COUNT_RESET;
         clr_addr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff            <= idx_in;
      round_ff          <= round_in;
      pick_ff           <= pick_in;
      bkey_ff           <= bkey_in;
      found_ff          <= found_in;
      rv_ff             <= rv_in;
      ridx_ff           <= ridx_in;
      key_ff            <= key_in;
      par_ff            <= par_in;
      in_tree_ff        <= in_tree_in;
      known_ff          <= known_in;
      rsp_parent_ff     <= rsp_parent_in;
      rsp_child_ff      <= rsp_child_in;
      rsp_has_parent_ff <= rsp_has_parent_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_parent     = rsp_parent_ff;
   assign rsp_child      = rsp_child_ff;
   assign rsp_has_parent = rsp_has_parent_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

### sv/prim_minimum_spanning_tree_core.sv
// Channel   Handshake            Payload
// request   start / busy         req_cmd, req_row, req_col, req_weight
// response  rsp_valid (strobe)   rsp_parent, rsp_child, rsp_has_parent, rsp_last
// config    csr_wr_en            csr_wr_data (node_count)
//
// A matrix write is taken in idle without leaving it; a run makes a scan pass and a relax
// pass over the nodes in each round, the relax pass reading the single matrix read port.
// Results leave one per cycle, registered, in the cycle after each emit step.
// After reset, busy stays high while the matrix is cleared.
// Results cannot be held off; each is valid for one cycle only.
module prim_minimum_spanning_tree_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_cmd,
   input  logic [prim_mst_pkg::NODE_BITS-1:0]    req_row,
   input  logic [prim_mst_pkg::NODE_BITS-1:0]    req_col,
   input  logic [prim_mst_pkg::WEIGHT_BITS-1:0]  req_weight,
   output logic                                  rsp_valid,
   output logic [prim_mst_pkg::NODE_BITS-1:0]    rsp_parent,
   output logic [prim_mst_pkg::NODE_BITS-1:0]    rsp_child,
   output logic                                  rsp_has_parent,
   output logic                                  rsp_last,
   input  logic                                  csr_wr_en,
   input  logic [prim_mst_pkg::CNT_BITS-1:0]     csr_wr_data
);

   prim_mst_pkg::cmd_type cmd;
   prim_mst_pkg::sts_type sts;

   prim_mst_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_cmd(req_cmd),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy)
   );

   prim_mst_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_weight    (req_weight),
      .rsp_valid     (rsp_valid),
      .rsp_parent    (rsp_parent),
      .rsp_child     (rsp_child),
      .rsp_has_parent(rsp_has_parent),
      .rsp_last      (rsp_last)
   );

endmodule

### tb/tb_prim_minimum_spanning_tree_core.sv
module tb_prim_minimum_spanning_tree_core;

   localparam int ITEM_TARGET  = 380;
   localparam int SETTLE_WAIT  = 4;
   localparam int TAIL_CYCLES  = 40;
   localparam int STALL_LIMIT  = 4000;
   localparam int PRINT_LIMIT  = 100;

   typedef logic [prim_mst_pkg::NODE_BITS-1:0]   node_type;
   typedef logic [prim_mst_pkg::WEIGHT_BITS-1:0] weight_type;
   typedef logic [prim_mst_pkg::KEY_BITS-1:0]    key_type;
   typedef logic [prim_mst_pkg::CNT_BITS-1:0]    count_type;

   typedef enum logic [1:0] {
      ACT_ITEM,
      ACT_CSR,
      ACT_SETTLE
   } action_type;

   typedef struct {
      action_type action;
      logic       cmd;
      node_type   row;
      node_type   col;
      weight_type weight;
      count_type  count;
   } step_type;

   typedef struct {
      node_type parent;
      node_type child;
      logic     has_parent;
      logic     last;
   } tree_link_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       start       = 1'b0;
   logic       busy;
   logic       req_cmd     = prim_mst_pkg::CMD_WRITE;
   node_type   req_row     = '0;
   node_type   req_col     = '0;
   weight_type req_weight  = '0;
   logic       rsp_valid;
   node_type   rsp_parent;
   node_type   rsp_child;
   logic       rsp_has_parent;
   logic       rsp_last;
   logic       csr_wr_en   = 1'b0;
   count_type  csr_wr_data = '0;

   step_type      pending_q[$];
   tree_link_type tree_links_q[$];
   weight_type    adj[prim_mst_pkg::MAX_NODES][prim_mst_pkg::MAX_NODES];
   count_type     node_count_shadow;
   int            errors = 0;
   int            items_queued = 0;

   prim_minimum_spanning_tree_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_weight     (req_weight),
      .rsp_valid      (rsp_valid),
      .rsp_parent     (rsp_parent),
      .rsp_child      (rsp_child),
      .rsp_has_parent (rsp_has_parent),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(string msg);
      if (errors < PRINT_LIMIT) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
      errors++;
   endtask

   function automatic int active_nodes(count_type cnt);
      int n;
      n = int'(cnt);
      if (n < 2) n = 2;
      if (n > prim_mst_pkg::MAX_NODES) n = prim_mst_pkg::MAX_NODES;
      return n;
   endfunction

   // dense Prim from node 0, ties to the lowest index
   task automatic predict_tree_links();
      int            n, pick, i, r, c;
      key_type       key[prim_mst_pkg::MAX_NODES];
      logic          visited[prim_mst_pkg::MAX_NODES];
      node_type      par[prim_mst_pkg::MAX_NODES];
      logic          known[prim_mst_pkg::MAX_NODES];
      tree_link_type link;
      n = active_nodes(node_count_shadow);
      for (i = 0; i < prim_mst_pkg::MAX_NODES; i++) begin
         key[i]     = prim_mst_pkg::KEY_INF;
         visited[i] = 1'b0;
         par[i]     = '0;
         known[i]   = 1'b0;
      end
      key[0] = '0;
      for (r = 0; r + 1 < n; r++) begin
         pick = -1;
         for (i = 0; i < n; i++) begin
            if (!visited[i] && (pick < 0 || key[i] < key[pick])) pick = i;
         end
         visited[pick] = 1'b1;
         for (i = 0; i < n; i++) begin
            if (adj[pick][i] != '0 && !visited[i] && key_type'(adj[pick][i]) < key[i]) begin
               key[i]   = key_type'(adj[pick][i]);
               par[i]   = node_type'(pick);
               known[i] = 1'b1;
            end
         end
      end
      for (c = 1; c < n; c++) begin
         link.parent     = known[c] ? par[c] : node_type'(0);
         link.child      = node_type'(c);
         link.has_parent = known[c];
         link.last       = (c == n - 1);
         tree_links_q.insert(tree_links_q.size(), link);
      end
   endtask

   task automatic apply_transaction(step_type t);
      if (t.cmd == prim_mst_pkg::CMD_WRITE) begin
         adj[t.row][t.col] = t.weight;
      end else begin
         predict_tree_links();
      end
   endtask

   task automatic add_write(int row, int col, int weight);
      step_type s;
      s.action = ACT_ITEM;
      s.cmd    = prim_mst_pkg::CMD_WRITE;
      s.row    = node_type'(row);
      s.col    = node_type'(col);
      s.weight = weight_type'(weight);
      s.count  = '0;
      pending_q.insert(pending_q.size(), s);
      items_queued++;
   endtask

   task automatic add_run();
      step_type s;
      s.action = ACT_ITEM;
      s.cmd    = prim_mst_pkg::CMD_RUN;
      s.row    = node_type'($urandom);
      s.col    = node_type'($urandom);
      s.weight = weight_type'($urandom);
      s.count  = '0;
      pending_q.insert(pending_q.size(), s);
      items_queued++;
   endtask

   task automatic add_control(action_type act, int cnt);
      step_type s;
      s.action = act;
      s.cmd    = prim_mst_pkg::CMD_WRITE;
      s.row    = '0;
      s.col    = '0;
      s.weight = '0;
      s.count  = count_type'(cnt);
      pending_q.insert(pending_q.size(), s);
   endtask

   function automatic int pick_weight();
      int mode;
      mode = $urandom_range(0, 9);
      if (mode < 6) return $urandom_range(1, 4);
      if (mode < 8) return $urandom_range(0, 65535);
      if (mode == 8) return 0;
      return 65535;
   endfunction

   // driver: one transaction at a time, random gaps, control steps wait for idle
   always @(posedge clock) begin : drive
      step_type head;
      logic     next_start;
      logic     next_wr;
      int       gap_left;
      int       settle;
      int       burst_left;
      if (reset) begin
         start             <= 1'b0;
         csr_wr_en         <= 1'b0;
         gap_left          = 0;
         settle            = 0;
         burst_left        = 0;
         node_count_shadow = prim_mst_pkg::NODE_COUNT_RESET;
         for (int i = 0; i < prim_mst_pkg::MAX_NODES; i++) begin
            for (int j = 0; j < prim_mst_pkg::MAX_NODES; j++) adj[i][j] = '0;
         end
      end else begin
         if (csr_wr_en) node_count_shadow = csr_wr_data;
         next_start = start;
         next_wr    = 1'b0;
         if (start && !busy) begin
            apply_transaction(head);
            next_start = 1'b0;
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() > 0) begin
               if (pending_q[0].action == ACT_ITEM) begin
                  head = pending_q.pop_front();
                  req_cmd    <= head.cmd;
                  req_row    <= head.row;
                  req_col    <= head.col;
                  req_weight <= head.weight;
                  next_start = 1'b1;
                  if (burst_left > 0) begin
                     burst_left--;
                     gap_left = 0;
                  end else begin
                     gap_left = $urandom_range(0, 4);
                     if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 24);
                  end
               end else if (tree_links_q.size() == 0 && !busy && !start) begin
                  if (settle < SETTLE_WAIT) begin
                     settle++;
                  end else begin
                     settle = 0;
                     if (pending_q[0].action == ACT_CSR) begin
                        next_wr = 1'b1;
                        csr_wr_data <= pending_q[0].count;
                     end
                     void'(pending_q.pop_front());
                  end
               end else begin
                  settle = 0;
               end
            end
         end
         start     <= next_start;
         csr_wr_en <= next_wr;
      end
   end

   // monitor: results are strobed, compare against the oldest expected link
   always @(posedge clock) begin : monitor
      tree_link_type want;
      if (!reset && rsp_valid) begin
         if (tree_links_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result child %0d", rsp_child));
         end else begin
            want = tree_links_q.pop_front();
            if (rsp_child !== want.child)
               report_mismatch($sformatf("child got %0d want %0d", rsp_child, want.child));
            if (rsp_parent !== want.parent)
               report_mismatch($sformatf("child %0d parent got %0d want %0d",
                                         want.child, rsp_parent, want.parent));
            if (rsp_has_parent !== want.has_parent)
               report_mismatch($sformatf("child %0d has_parent got %0b want %0b",
                                         want.child, rsp_has_parent, want.has_parent));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("child %0d last got %0b want %0b",
                                         want.child, rsp_last, want.last));
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid || csr_wr_en) quiet = 0;
         else quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int roll, cnt, n, edges, r, c, w;
      // empty matrix at the reset node count: nothing reachable
      add_run();
      add_write(0, 1, 16'hFFFF);
      add_write(1, 0, 16'hFFFF);
      add_write(1, 2, 1);
      add_write(0, 2, 16'h8000);
      add_write(3, 3, 5);
      add_write(15, 15, 16'h7FFF);
      add_write(15, 14, 1);
      add_write(14, 0, 2);
      add_write(2, 3, 3);
      add_write(2, 4, 3);
      add_run();
      add_write(0, 2, 0);
      add_control(ACT_SETTLE, 0);
      add_run();
      add_control(ACT_CSR, 2);
      add_run();
      add_control(ACT_CSR, 0);
      add_run();
      add_control(ACT_CSR, 1);
      add_write(0, 1, 0);
      add_run();
      add_control(ACT_CSR, 31);
      add_run();
      add_control(ACT_CSR, 17);
      add_write(15, 0, 16'hAAAA);
      add_write(5, 10, 16'h5555);
      add_run();

      while (items_queued < ITEM_TARGET) begin
         roll = $urandom_range(0, 9);
         if (roll < 6) cnt = $urandom_range(2, 6);
         else if (roll < 9) cnt = $urandom_range(7, 16);
         else cnt = $urandom_range(0, 31);
         add_control(ACT_CSR, cnt);
         n = active_nodes(count_type'(cnt));
         repeat ($urandom_range(1, 3)) begin
            edges = $urandom_range(0, 2 * n);
            repeat (edges) begin
               if ($urandom_range(0, 9) < 8) begin
                  r = $urandom_range(0, n - 1);
                  c = $urandom_range(0, n - 1);
                  w = pick_weight();
                  add_write(r, c, w);
                  if ($urandom_range(0, 1) == 0) add_write(c, r, w);
               end else begin
                  add_write($urandom_range(0, prim_mst_pkg::MAX_NODES - 1),
                            $urandom_range(0, prim_mst_pkg::MAX_NODES - 1),
                            $urandom_range(0, 65535));
               end
            end
            if ($urandom_range(0, 7) == 0) add_control(ACT_SETTLE, 0);
            add_run();
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!(pending_q.size() == 0 && !start && !busy && tree_links_q.size() == 0))
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tree_links_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived", tree_links_q.size()));
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
